/* sv/rmq_pkg.sv */
// Shared constants, payload types and the saturation helper for the
// rotation-matrix-to-quaternion pipeline. No dependencies.
package rmq_pkg;

	localparam int FRAC_BITS = 16;
	localparam int M_W       = 18;
	localparam int SUM_W     = M_W + 2;
	localparam int T_W       = M_W + 1;
	localparam int NUM_W     = M_W + 1;
	localparam int ROOT_W    = (T_W + FRAC_BITS + 2 + 1) / 2;
	localparam int N_W       = 2 * ROOT_W;
	localparam int Q_W       = NUM_W + FRAC_BITS;
	localparam int OUT_W     = Q_W + 2;

	localparam longint ONE_FX    = longint'(1) << FRAC_BITS;
	localparam longint FIELD_MAX = (longint'(1) << (M_W - 1)) - 1;
	localparam longint SAT_LIM   = (ONE_FX < FIELD_MAX) ? ONE_FX : FIELD_MAX;

	localparam int SQ_LAT = ROOT_W;
	localparam int DV_LAT = Q_W + 1;
	localparam int LAT    = SQ_LAT + DV_LAT + 2;

	localparam logic [1:0] BR_W = 2'd0;
	localparam logic [1:0] BR_X = 2'd1;
	localparam logic [1:0] BR_Y = 2'd2;
	localparam logic [1:0] BR_Z = 2'd3;

	typedef struct packed {
		logic [1:0]              br;
		logic [T_W-1:0]          t;
		logic signed [NUM_W-1:0] n0;
		logic signed [NUM_W-1:0] n1;
		logic signed [NUM_W-1:0] n2;
	} front_t;

	typedef struct packed {
		logic [1:0]        br;
		logic [ROOT_W-3:0] quarter;
		logic              zero;
	} side_t;

	function automatic logic signed [M_W-1:0] sat(input logic signed [OUT_W-1:0] v);
		logic signed [OUT_W-1:0] lim;
		lim = OUT_W'(SAT_LIM);
		if (v > lim)
			return M_W'(lim);
		else if (v < -lim)
			return M_W'(-lim);
		else
			return v[M_W-1:0];
	endfunction

endpackage

/* sv/rmq_front.sv */
// Branch selection, scale term and off-diagonal numerators, one register stage.
// Depends on rmq_pkg.
module rmq_front (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [rmq_pkg::M_W-1:0]    m [9],
	output rmq_pkg::front_t                   fr_s1
);
	localparam int SW = rmq_pkg::SUM_W;
	localparam int NW = rmq_pkg::NUM_W;

	logic signed [SW-1:0] e [9];
	logic signed [SW-1:0] tr, t_raw, one;
	rmq_pkg::front_t      fr;

	always_comb begin
		for (int i = 0; i < 9; i++)
			e[i] = SW'(m[i]);
		one   = SW'(rmq_pkg::ONE_FX);
		tr    = e[0] + e[4] + e[8];
		fr    = '0;
		if (tr > 0) begin
			fr.br = rmq_pkg::BR_W;
			t_raw = one + tr;
			fr.n0 = NW'(m[7]) - NW'(m[5]);
			fr.n1 = NW'(m[2]) - NW'(m[6]);
			fr.n2 = NW'(m[3]) - NW'(m[1]);
		end else if (m[0] > m[4] && m[0] > m[8]) begin
			fr.br = rmq_pkg::BR_X;
			t_raw = one + e[0] - e[4] - e[8];
			fr.n0 = NW'(m[7]) - NW'(m[5]);
			fr.n1 = NW'(m[1]) + NW'(m[3]);
			fr.n2 = NW'(m[2]) + NW'(m[6]);
		end else if (m[4] > m[8]) begin
			fr.br = rmq_pkg::BR_Y;
			t_raw = one + e[4] - e[0] - e[8];
			fr.n0 = NW'(m[2]) - NW'(m[6]);
			fr.n1 = NW'(m[1]) + NW'(m[3]);
			fr.n2 = NW'(m[5]) + NW'(m[7]);
		end else begin
			fr.br = rmq_pkg::BR_Z;
			t_raw = one + e[8] - e[0] - e[4];
			fr.n0 = NW'(m[3]) - NW'(m[1]);
			fr.n1 = NW'(m[2]) + NW'(m[6]);
			fr.n2 = NW'(m[5]) + NW'(m[7]);
		end
		fr.t = (t_raw < 0) ? '0 : t_raw[rmq_pkg::T_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en)
			fr_s1 <= fr;
	end
endmodule

/* sv/rmq_sqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Depends on rmq_pkg.
module rmq_sqrt (
	input  logic                          clk,
	input  logic                          en,
	input  logic [rmq_pkg::T_W-1:0]       t,
	output logic [rmq_pkg::ROOT_W-1:0]    root
);
	localparam int RW = rmq_pkg::ROOT_W;
	localparam int NW = rmq_pkg::N_W;
	localparam int EW = RW + 2;

	logic [EW-1:0] rem_s  [RW];
	logic [RW-1:0] root_s [RW];
	logic [NW-1:0] n_s    [RW];

	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic [EW-1:0] rem_p, rem_in, trial;
		logic [RW-1:0] root_p;
		logic [NW-1:0] n_p;
		if (i == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign n_p    = NW'({t, {(rmq_pkg::FRAC_BITS + 2){1'b0}}});
		end else begin : g_rest
			assign rem_p  = rem_s[i-1];
			assign root_p = root_s[i-1];
			assign n_p    = n_s[i-1];
		end
		assign rem_in = {rem_p[EW-3:0], n_p[NW-1 -: 2]};
		assign trial  = {root_p, 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i] <= {n_p[NW-3:0], 2'b00};
				if (rem_in >= trial) begin
					rem_s[i]  <= rem_in - trial;
					root_s[i] <= {root_p[RW-2:0], 1'b1};
				end else begin
					rem_s[i]  <= rem_in;
					root_s[i] <= {root_p[RW-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[RW-1];
endmodule

/* sv/rmq_div.sv */
// Pipelined restoring divider: |num| * 2^FRAC_BITS / s rounded to nearest.
// Depends on rmq_pkg.
module rmq_div (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [rmq_pkg::NUM_W-1:0]   num,
	input  logic [rmq_pkg::ROOT_W-1:0]         s,
	output logic [rmq_pkg::Q_W-1:0]            mag,
	output logic                               neg
);
	localparam int RW = rmq_pkg::ROOT_W;
	localparam int QW = rmq_pkg::Q_W;
	localparam int NW = rmq_pkg::NUM_W;

	logic [NW-1:0] abs_n;
	logic [QW-1:0] d_s0;
	logic [RW-1:0] s_s0;
	logic          neg_s0;

	logic [RW-1:0] rem_s [QW];
	logic [QW-1:0] dq_s  [QW];
	logic [RW-1:0] dv_s  [QW];
	logic          ng_s  [QW];

	assign abs_n = num[NW-1] ? NW'(-num) : NW'(num);

	always_ff @(posedge clk) begin
		if (en) begin
			d_s0   <= (QW'(abs_n) << rmq_pkg::FRAC_BITS) + QW'(s >> 1);
			s_s0   <= s;
			neg_s0 <= num[NW-1];
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [RW-1:0] rem_p, dv_p;
		logic [QW-1:0] dq_p;
		logic          ng_p;
		logic [RW:0]   rem_in;
		if (k == 0) begin : g_first
			assign rem_p = '0;
			assign dq_p  = d_s0;
			assign dv_p  = s_s0;
			assign ng_p  = neg_s0;
		end else begin : g_rest
			assign rem_p = rem_s[k-1];
			assign dq_p  = dq_s[k-1];
			assign dv_p  = dv_s[k-1];
			assign ng_p  = ng_s[k-1];
		end
		assign rem_in = {rem_p, dq_p[QW-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k] <= dv_p;
				ng_s[k] <= ng_p;
				if (rem_in >= {1'b0, dv_p}) begin
					rem_s[k] <= RW'(rem_in - {1'b0, dv_p});
					dq_s[k]  <= {dq_p[QW-2:0], 1'b1};
				end else begin
					rem_s[k] <= rem_in[RW-1:0];
					dq_s[k]  <= {dq_p[QW-2:0], 1'b0};
				end
			end
		end
	end

	assign mag = dq_s[QW-1];
	assign neg = ng_s[QW-1];
endmodule

/* sv/rmq_back.sv */
// Component placement by branch, sign forcing and saturation, output register.
// Depends on rmq_pkg.
module rmq_back (
	input  logic                             clk,
	input  logic                             en,
	input  logic                             force_pos,
	input  rmq_pkg::side_t                   sd,
	input  logic [rmq_pkg::Q_W-1:0]          mag [3],
	input  logic                             neg [3],
	output logic signed [rmq_pkg::M_W-1:0]   quat_w,
	output logic signed [rmq_pkg::M_W-1:0]   quat_x,
	output logic signed [rmq_pkg::M_W-1:0]   quat_y,
	output logic signed [rmq_pkg::M_W-1:0]   quat_z,
	output logic [1:0]                       branch_taken
);
	localparam int OW = rmq_pkg::OUT_W;

	logic signed [OW-1:0] qd [3];
	logic signed [OW-1:0] big, w, x, y, z;

	always_comb begin
		for (int k = 0; k < 3; k++)
			qd[k] = neg[k] ? -signed'(OW'(mag[k])) : signed'(OW'(mag[k]));
		big = signed'(OW'(sd.quarter));
		case (sd.br)
			rmq_pkg::BR_W: begin w = big;   x = qd[0]; y = qd[1]; z = qd[2]; end
			rmq_pkg::BR_X: begin w = qd[0]; x = big;   y = qd[1]; z = qd[2]; end
			rmq_pkg::BR_Y: begin w = qd[0]; x = qd[1]; y = big;   z = qd[2]; end
			default:       begin w = qd[0]; x = qd[1]; y = qd[2]; z = big;   end
		endcase
		if (sd.zero) begin
			w = '0; x = '0; y = '0; z = '0;
		end
		if (force_pos && w < 0) begin
			w = -w; x = -x; y = -y; z = -z;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat_w       <= rmq_pkg::sat(w);
			quat_x       <= rmq_pkg::sat(x);
			quat_y       <= rmq_pkg::sat(y);
			quat_z       <= rmq_pkg::sat(z);
			branch_taken <= sd.br;
		end
	end
endmodule

/* sv/rotation_matrix_to_quaternion.sv */
// Rotation matrix to unit quaternion, four-branch trace method.
// Pipeline stages: 1 front stage, 19 square-root stages, 36 divider stages,
// 1 output stage. Throughput one transaction per cycle; the whole pipeline
// holds while a result waits on out_ready. arst_n clears the valid bits and
// sets force_q to 1. Depends on rmq_pkg and the rmq_* modules.
module rotation_matrix_to_quaternion (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [rmq_pkg::M_W-1:0]   m00,
	input  logic signed [rmq_pkg::M_W-1:0]   m01,
	input  logic signed [rmq_pkg::M_W-1:0]   m02,
	input  logic signed [rmq_pkg::M_W-1:0]   m10,
	input  logic signed [rmq_pkg::M_W-1:0]   m11,
	input  logic signed [rmq_pkg::M_W-1:0]   m12,
	input  logic signed [rmq_pkg::M_W-1:0]   m20,
	input  logic signed [rmq_pkg::M_W-1:0]   m21,
	input  logic signed [rmq_pkg::M_W-1:0]   m22,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [rmq_pkg::M_W-1:0]   quat_w,
	output logic signed [rmq_pkg::M_W-1:0]   quat_x,
	output logic signed [rmq_pkg::M_W-1:0]   quat_y,
	output logic signed [rmq_pkg::M_W-1:0]   quat_z,
	output logic [1:0]                       branch_taken
);
	localparam int SQ = rmq_pkg::SQ_LAT;
	localparam int DV = rmq_pkg::DV_LAT;
	localparam int LT = rmq_pkg::LAT;

	logic                           en;
	logic                           force_q;
	logic                           vld_q [LT];
	logic signed [rmq_pkg::M_W-1:0] m [9];
	rmq_pkg::front_t                fr_s1;
	rmq_pkg::front_t                fr_d [SQ];
	rmq_pkg::side_t                 sd_d [DV];
	rmq_pkg::side_t                 sd_in;
	logic [rmq_pkg::ROOT_W-1:0]     root;
	logic [rmq_pkg::Q_W-1:0]        mag [3];
	logic                           neg [3];
	logic signed [rmq_pkg::NUM_W-1:0] nums [3];

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;
	assign out_valid = vld_q[LT-1];

	assign m = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_q <= 1'b1;
		end else if (cfg_valid) begin
			force_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LT; i++)
				vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < LT; i++)
				vld_q[i] <= vld_q[i-1];
		end
	end

	rmq_front u_front (.clk(clk), .en(en), .m(m), .fr_s1(fr_s1));

	rmq_sqrt u_sqrt (.clk(clk), .en(en), .t(fr_s1.t), .root(root));

	always_ff @(posedge clk) begin
		if (en) begin
			fr_d[0] <= fr_s1;
			for (int i = 1; i < SQ; i++)
				fr_d[i] <= fr_d[i-1];
			sd_d[0] <= sd_in;
			for (int i = 1; i < DV; i++)
				sd_d[i] <= sd_d[i-1];
		end
	end

	always_comb begin
		sd_in.br      = fr_d[SQ-1].br;
		sd_in.quarter = root[rmq_pkg::ROOT_W-1:2];
		sd_in.zero    = (root == '0);
		nums[0]       = fr_d[SQ-1].n0;
		nums[1]       = fr_d[SQ-1].n1;
		nums[2]       = fr_d[SQ-1].n2;
	end

	for (genvar k = 0; k < 3; k++) begin : g_div
		rmq_div u_div (
			.clk(clk), .en(en), .num(nums[k]), .s(root), .mag(mag[k]), .neg(neg[k])
		);
	end

	rmq_back u_back (
		.clk(clk), .en(en), .force_pos(force_q), .sd(sd_d[DV-1]), .mag(mag), .neg(neg),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.branch_taken(branch_taken)
	);
endmodule
